FILE: rtl/bpfr_pkg.sv
package bpfr_pkg;

   typedef enum logic [2:0] {
      CMD_PIN   = 3'd0,
      CMD_UNPIN = 3'd1,
      CMD_DIRTY = 3'd2,
      CMD_FORCE = 3'd3,
      CMD_FLUSH = 3'd4
   } cmd_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_RES  = 2'd1;
   localparam logic [1:0] ST_NO_VICT  = 2'd2;

   localparam logic [1:0] IO_NONE  = 2'd0;
   localparam logic [1:0] IO_READ  = 2'd1;
   localparam logic [1:0] IO_WRITE = 2'd2;

   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_FRAMES = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [30:0] page_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  frame_index;
      logic [1:0]  io_request;
      logic [30:0] io_page;
      logic [31:0] reads_done;
      logic [31:0] writes_done;
      logic        last_result;
   } rsp_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_SCAN     = 4'd1,  // one step of a page/victim walk
      OP_CLR      = 4'd2,  // reset walk index and search flags
      OP_HIT_PIN  = 4'd3,
      OP_UNPIN    = 4'd4,
      OP_DIRTY    = 4'd5,
      OP_FORCE    = 4'd6,
      OP_EVICT_WB = 4'd7,
      OP_AGE      = 4'd8,  // one aging step
      OP_LOAD     = 4'd9,
      OP_FLUSH_WB = 4'd10,
      OP_EMIT_ST  = 4'd11,
      OP_LRU_HIT  = 4'd12
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] st;
   } cmd_bus_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
      logic empty_found;
      logic victim_found;
      logic victim_dirty;
      logic flush_hit;
   } stat_bus_type;

endpackage

FILE: rtl/bpfr_datapath.sv
module bpfr_datapath #(
   parameter int NUM_FRAMES     = 16,
   parameter int FIX_COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            frames_cfg,
   input  bpfr_pkg::req_type     req,
   input  bpfr_pkg::cmd_bus_type cmd,
   output bpfr_pkg::stat_bus_type stat,
   output bpfr_pkg::rsp_type     rsp_word
);
   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);

   logic [30:0]             page_mem [NUM_FRAMES];
   logic [NUM_FRAMES-1:0]   valid_ff, dirty_ff;
   logic [FIX_COUNT_BITS-1:0] fix_ff [NUM_FRAMES];
   logic [FW-1:0]           rank_ff [NUM_FRAMES];
   logic [31:0]             rd_cnt_ff, wr_cnt_ff;
   logic [CW-1:0]           idx_ff;
   logic [FW-1:0]           sel_ff, vic_ff;
   logic                    hit_ff, empty_ff, vfound_ff;
   logic [FW-1:0]           best_ff, old_rank_ff;
   logic                    old_valid_ff;
   logic [CW-1:0]           n_mgd;
   logic [FW-1:0]           i;
   logic                    in_range;

   assign n_mgd = (frames_cfg == 5'd0) ? CW'(1) :
                  ({27'd0, frames_cfg} > 32'(NUM_FRAMES)) ? CW'(NUM_FRAMES) :
                  CW'(frames_cfg);
   assign i = idx_ff[FW-1:0];
   assign in_range = idx_ff < n_mgd;

   assign stat.scan_done    = !in_range;
   assign stat.hit          = hit_ff;
   assign stat.empty_found  = empty_ff;
   assign stat.victim_found = vfound_ff;
   assign stat.victim_dirty = dirty_ff[vic_ff];
   assign stat.flush_hit    = in_range && valid_ff[i] && dirty_ff[i] && fix_ff[i] == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         dirty_ff  <= '0;
         rd_cnt_ff <= '0;
         wr_cnt_ff <= '0;
         idx_ff    <= '0;
         for (int k = 0; k < NUM_FRAMES; k++) begin
            fix_ff[k]  <= '0;
            rank_ff[k] <= '0;
         end
      end else begin
         case (cmd.op)
            bpfr_pkg::OP_CLR: begin
               idx_ff <= '0; hit_ff <= 1'b0; empty_ff <= 1'b0; vfound_ff <= 1'b0;
               best_ff <= '0;
            end
            bpfr_pkg::OP_SCAN: begin
               // one frame per cycle: page match, first empty, oldest unpinned
               if (in_range) begin
                  if (!hit_ff && valid_ff[i] && page_mem[i] == req.page_number) begin
                     hit_ff <= 1'b1; sel_ff <= i;
                  end
                  if (!empty_ff && !valid_ff[i]) begin
                     empty_ff <= 1'b1; vic_ff <= i;
                  end else if (!empty_ff && fix_ff[i] == '0 &&
                               (!vfound_ff || rank_ff[i] > best_ff)) begin
                     vfound_ff <= 1'b1; vic_ff <= i; best_ff <= rank_ff[i];
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            bpfr_pkg::OP_HIT_PIN: begin
               if (fix_ff[sel_ff] != '1) fix_ff[sel_ff] <= fix_ff[sel_ff] + 1'b1;
               old_rank_ff <= rank_ff[sel_ff]; old_valid_ff <= 1'b1; vic_ff <= sel_ff;
               idx_ff <= '0;
            end
            bpfr_pkg::OP_LRU_HIT: begin
               old_rank_ff <= rank_ff[vic_ff]; old_valid_ff <= valid_ff[vic_ff];
               idx_ff <= '0;
            end
            bpfr_pkg::OP_AGE: begin
               // age frames newer than the target, one per cycle
               if (in_range) begin
                  if (i != vic_ff && valid_ff[i] &&
                      (!old_valid_ff || rank_ff[i] < old_rank_ff) &&
                      rank_ff[i] != FW'(NUM_FRAMES - 1))
                     rank_ff[i] <= rank_ff[i] + 1'b1;
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            bpfr_pkg::OP_UNPIN:
               if (fix_ff[sel_ff] != '0) fix_ff[sel_ff] <= fix_ff[sel_ff] - 1'b1;
            bpfr_pkg::OP_DIRTY: dirty_ff[sel_ff] <= 1'b1;
            bpfr_pkg::OP_FORCE: begin
               dirty_ff[sel_ff] <= 1'b0; wr_cnt_ff <= wr_cnt_ff + 1'b1;
            end
            bpfr_pkg::OP_EVICT_WB: wr_cnt_ff <= wr_cnt_ff + 1'b1;
            bpfr_pkg::OP_LOAD: begin
               valid_ff[vic_ff] <= 1'b1; dirty_ff[vic_ff] <= 1'b0;
               fix_ff[vic_ff]   <= FIX_COUNT_BITS'(1); rank_ff[vic_ff] <= '0;
               page_mem[vic_ff] <= req.page_number;
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
            end
            bpfr_pkg::OP_FLUSH_WB: begin
               if (stat.flush_hit) begin
                  dirty_ff[i] <= 1'b0; wr_cnt_ff <= wr_cnt_ff + 1'b1;
               end
               idx_ff <= idx_ff + CW'(1);
            end
            default: ;
         endcase
         if (cmd.op == bpfr_pkg::OP_AGE && !in_range && old_valid_ff && vic_ff == sel_ff &&
             hit_ff)
            rank_ff[vic_ff] <= '0;
      end
   end

   // result word, built combinationally from current state and the op
   always_comb begin
      rsp_word = '0;
      rsp_word.status      = cmd.st;
      rsp_word.reads_done  = rd_cnt_ff;
      rsp_word.writes_done = wr_cnt_ff;
      rsp_word.last_result = 1'b1;
      case (cmd.op)
         bpfr_pkg::OP_HIT_PIN, bpfr_pkg::OP_UNPIN, bpfr_pkg::OP_DIRTY:
            rsp_word.frame_index = 4'(sel_ff);
         bpfr_pkg::OP_FORCE: begin
            rsp_word.frame_index = 4'(sel_ff);
            rsp_word.io_request  = bpfr_pkg::IO_WRITE;
            rsp_word.io_page     = page_mem[sel_ff];
            rsp_word.writes_done = wr_cnt_ff + 1'b1;
         end
         bpfr_pkg::OP_EVICT_WB: begin
            rsp_word.frame_index = 4'(vic_ff);
            rsp_word.io_request  = bpfr_pkg::IO_WRITE;
            rsp_word.io_page     = page_mem[vic_ff];
            rsp_word.writes_done = wr_cnt_ff + 1'b1;
            rsp_word.last_result = 1'b0;
         end
         bpfr_pkg::OP_LOAD: begin
            rsp_word.frame_index = 4'(vic_ff);
            rsp_word.io_request  = bpfr_pkg::IO_READ;
            rsp_word.io_page     = req.page_number;
            rsp_word.reads_done  = rd_cnt_ff + 1'b1;
         end
         bpfr_pkg::OP_FLUSH_WB: begin
            rsp_word.frame_index = 4'(i);
            rsp_word.io_request  = bpfr_pkg::IO_WRITE;
            rsp_word.io_page     = page_mem[i];
            rsp_word.writes_done = wr_cnt_ff + 1'b1;
            rsp_word.last_result = 1'b0;
         end
         default: ;
      endcase
   end
endmodule

FILE: rtl/bpfr_ctrl.sv
module bpfr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mode,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             command,
   input  bpfr_pkg::stat_bus_type stat,
   output bpfr_pkg::cmd_bus_type  cmd,
   input  bpfr_pkg::rsp_type      rsp_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bpfr_pkg::rsp_type      rsp
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_DEC   = 9'b000000100,
      S_AGE   = 9'b000001000,
      S_LOAD  = 9'b000010000,
      S_FLUSH = 9'b000100000,
      S_EMIT  = 9'b001000000,
      S_WAIT  = 9'b010000000,
      S_WB    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic       hitage_ff, hitage_in;
   logic       rsp_valid_ff, rsp_valid_in;
   bpfr_pkg::rsp_type rsp_ff, rsp_in;
   logic       push, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; hitage_in = hitage_ff;
      cmd = '{op: bpfr_pkg::OP_NONE, st: bpfr_pkg::ST_OK};
      push = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd_in = command; cmd.op = bpfr_pkg::OP_CLR;
            state_in = (command == bpfr_pkg::CMD_FLUSH) ? S_FLUSH : S_SCAN;
            if (command > bpfr_pkg::CMD_FLUSH) state_in = S_EMIT;
         end
         S_SCAN: begin
            cmd.op = bpfr_pkg::OP_SCAN;
            if (stat.scan_done) state_in = S_DEC;
         end
         S_DEC: if (out_free) begin
            push = 1'b1; state_in = S_WAIT;
            if (stat.hit) begin
               case (cmd_ff)
                  bpfr_pkg::CMD_PIN: begin
                     cmd.op = bpfr_pkg::OP_HIT_PIN;
                     hitage_in = 1'b1;
                     if (mode) state_in = S_AGE;
                  end
                  bpfr_pkg::CMD_UNPIN: cmd.op = bpfr_pkg::OP_UNPIN;
                  bpfr_pkg::CMD_DIRTY: cmd.op = bpfr_pkg::OP_DIRTY;
                  default:             cmd.op = bpfr_pkg::OP_FORCE;
               endcase
            end else if (cmd_ff != bpfr_pkg::CMD_PIN) begin
               cmd.st = bpfr_pkg::ST_NOT_RES;
            end else if (!stat.empty_found && !stat.victim_found) begin
               cmd.st = bpfr_pkg::ST_NO_VICT;
            end else begin
               hitage_in = 1'b0;
               if (!stat.empty_found && stat.victim_dirty) begin
                  cmd.op = bpfr_pkg::OP_EVICT_WB; state_in = S_WB;
               end else begin
                  push = 1'b0; cmd.op = bpfr_pkg::OP_LRU_HIT; state_in = S_AGE;
               end
            end
         end
         S_WB: begin
            cmd.op = bpfr_pkg::OP_LRU_HIT; state_in = S_AGE;
         end
         S_AGE: begin
            cmd.op = bpfr_pkg::OP_AGE;
            if (stat.scan_done) state_in = hitage_ff ? S_WAIT : S_LOAD;
         end
         S_LOAD: if (out_free) begin
            cmd.op = bpfr_pkg::OP_LOAD; push = 1'b1; state_in = S_WAIT;
         end
         S_FLUSH: begin
            if (stat.scan_done) state_in = S_EMIT;
            else if (!stat.flush_hit) cmd.op = bpfr_pkg::OP_FLUSH_WB;
            else if (out_free) begin
               cmd.op = bpfr_pkg::OP_FLUSH_WB; push = 1'b1;
            end
         end
         S_EMIT: if (out_free) begin
            push = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = push ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_in = push ? rsp_word : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; cmd_ff <= '0; hitage_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         cmd_ff <= cmd_in; hitage_ff <= hitage_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule

FILE: rtl/buffer_pool_frame_replacement.sv
// Buffer pool page-frame table with FIFO or LRU replacement. One command word
// is taken at a time; req_stall stays high until the controller is idle again,
// after its last result word has been loaded into the output register. A command
// walks the managed frames one per cycle in the datapath (page match, empty frame
// and victim search together); an LRU pin hit or a pin miss that takes a frame
// adds a second walk for aging. Flush all walks one frame per cycle unless a write
// word waits on rsp_stall. The output register lets the next command start while
// the final word is still waiting. Write csr_ only while idle.
module buffer_pool_frame_replacement #(
   parameter int NUM_FRAMES     = 16,
   parameter int FIX_COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bpfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bpfr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [4:0]        csr_data
);
   logic       mode_ff;
   logic [4:0] frames_ff;
   bpfr_pkg::req_type      req_ff;
   bpfr_pkg::cmd_bus_type  cmd;
   bpfr_pkg::stat_bus_type stat;
   bpfr_pkg::rsp_type      rsp_word;

   assign csr_ready = 1'b1;

   // CSR writes; hold the accepted command for the whole walk
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; frames_ff <= 5'd16;
      end else if (csr_valid) begin
         if (csr_index == bpfr_pkg::CSR_MODE) mode_ff <= csr_data[0];
         else frames_ff <= csr_data;
      end
      if (req_valid && !req_stall) req_ff <= req_data;
   end

   bpfr_ctrl u_ctrl (
      .clock, .reset, .mode(mode_ff), .req_valid, .req_stall,
      .command(req_data.command), .stat, .cmd, .rsp_word,
      .rsp_valid, .rsp_stall, .rsp(rsp_data)
   );

   bpfr_datapath #(.NUM_FRAMES(NUM_FRAMES), .FIX_COUNT_BITS(FIX_COUNT_BITS)) u_dp (
      .clock, .reset, .frames_cfg(frames_ff), .req(req_ff),
      .cmd, .stat, .rsp_word
   );
endmodule

FILE: rtl/bpfr_checker.sv
module bpfr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bpfr_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");
   a_io_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.io_request == bpfr_pkg::IO_NONE |-> rsp_data.io_page == '0)
      else $error("page set without request");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken during work");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != bpfr_pkg::ST_OK |-> rsp_data.last_result &&
      rsp_data.io_request == bpfr_pkg::IO_NONE)
      else $error("error result not final");
endmodule

bind buffer_pool_frame_replacement bpfr_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
